// File: rtl/ffca_pkg.sv
// Shared types and constants for the first-free channel allocator.
package ffca_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned CntW  = 32;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ChanW-1:0] channel;
  } req_t;

  typedef struct packed {
    logic [ChanW-1:0] granted;
    logic             is_busy;
    logic [ChanW-1:0] busy_count;
    logic [CntW-1:0]  grant_total;
    logic [CntW-1:0]  release_total;
  } result_t;

endpackage

// File: rtl/ffca_first_free.sv
// Lowest-free-channel finder: isolates the lowest set bit and encodes its index.
module ffca_first_free #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned IDX_W    = 3
) (
  input  logic [CHANNELS-1:0] free_i,
  output logic                found_o,
  output logic [CHANNELS-1:0] onehot_o,
  output logic [IDX_W-1:0]    idx_o
);

  // lowest set bit: x & -x
  assign onehot_o = free_i & (~free_i + CHANNELS'(1));
  assign found_o  = |free_i;

  // one-hot to binary; terms are independent ORs
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (onehot_o[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/ffca_core.sv
// Allocator state (busy map, busy count, totals) and per-request update logic.
module ffca_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ffca_pkg::req_t          req_i,
  output ffca_pkg::result_t       res_o,
  output logic [CHANNELS-1:0]     busy_map_o,
  output logic [ffca_pkg::ChanW-1:0] busy_cnt_o
);

  import ffca_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] busy_q, busy_d;
  logic [ChanW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]     grant_q, grant_d;
  logic [CntW-1:0]     rel_q, rel_d;

  logic [CHANNELS-1:0] chan_mask;
  logic [CHANNELS-1:0] free_oh;
  logic [IdxW-1:0]     free_idx;
  logic                free_found;
  logic                hit;
  logic [ChanW-1:0]    granted;
  logic                is_busy;

  ffca_first_free #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IdxW)
  ) u_first_free (
    .free_i   (~busy_q),
    .found_o  (free_found),
    .onehot_o (free_oh),
    .idx_o    (free_idx)
  );

  // decode of the 1-based id; 0 and out-of-range ids match nothing
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_mask[i] = (req_i.channel == ChanW'(i + 1));
    end
  end

  assign hit = |(busy_q & chan_mask);

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    grant_d = grant_q;
    rel_d   = rel_q;
    granted = '0;
    is_busy = 1'b0;
    case (req_i.op)
      OP_ACQUIRE: begin
        if (free_found) begin
          busy_d  = busy_q | free_oh;
          cnt_d   = cnt_q + ChanW'(1);
          grant_d = grant_q + CntW'(1);
          granted = ChanW'(free_idx) + ChanW'(1);
        end
      end
      OP_RELEASE: begin
        if (hit) begin
          busy_d = busy_q & ~chan_mask;
          cnt_d  = cnt_q - ChanW'(1);
          rel_d  = rel_q + CntW'(1);
        end
      end
      OP_QUERY: begin
        is_busy = hit;
      end
      OP_CLEAR: begin
        busy_d  = '0;
        cnt_d   = '0;
        grant_d = '0;
        rel_d   = '0;
      end
      default: begin
        busy_d = busy_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      cnt_q   <= '0;
      grant_q <= '0;
      rel_q   <= '0;
    end else if (en_i) begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      grant_q <= grant_d;
      rel_q   <= rel_d;
    end
  end

  assign res_o.granted       = granted;
  assign res_o.is_busy       = is_busy;
  assign res_o.busy_count    = cnt_d;
  assign res_o.grant_total   = grant_d;
  assign res_o.release_total = rel_d;

  assign busy_map_o = busy_q;
  assign busy_cnt_o = cnt_q;

endmodule

// File: rtl/first_free_channel_allocator.sv
// Top level of the first-free channel allocator: request and result registers around the core.
//
// Usage:
//   Request channel (in_valid_i / in_ready_o): operation_i selects acquire,
//   release, query or clear; channel_i is the 1-based id for release/query.
//   Result channel (out_valid_o / out_ready_i): one result per request with
//   granted_o, is_busy_o, busy_count_o, grant_total_o and release_total_o,
//   all as they stand after that request.
//   A request passes through the request register, then the result register,
//   before its result is visible. Throughput: one request per cycle while
//   out_ready_i is high; the whole update is a priority encode, a decode and a few adds.
//   Reset: all channels free, counters zero, both pipeline stages empty.
//   Stall: when out_ready_i is low the result register holds and the request
//   register can still take one more request; further requests wait on
//   in_ready_o. State is only updated when a request moves into the result
//   register, so stalls never lose or repeat a request.
//   CHANNELS sets the width of the busy map (1..255).
module first_free_channel_allocator #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [ffca_pkg::ChanW-1:0]  channel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffca_pkg::ChanW-1:0]  granted_o,
  output logic                        is_busy_o,
  output logic [ffca_pkg::ChanW-1:0]  busy_count_o,
  output logic [ffca_pkg::CntW-1:0]   grant_total_o,
  output logic [ffca_pkg::CntW-1:0]   release_total_o
);

  import ffca_pkg::*;

  // request register
  logic    req_vld_q;
  req_t    req_q;
  // result register
  logic    res_vld_q;
  result_t res_q;
  result_t res_d;

  logic                req_fire;
  logic                advance;
  logic [CHANNELS-1:0] busy_map;
  logic [ChanW-1:0]    busy_cnt;

  // result register can take a new entry when empty or being drained
  assign advance    = !res_vld_q || out_ready_i;
  assign in_ready_o = !req_vld_q || advance;
  assign req_fire   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_fire) begin
      req_vld_q <= 1'b1;
    end else if (advance) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.op      <= op_e'(operation_i);
      req_q.channel <= channel_i;
    end
  end

  // state commits exactly when the request moves to the result register
  ffca_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (req_vld_q && advance),
    .req_i      (req_q),
    .res_o      (res_d),
    .busy_map_o (busy_map),
    .busy_cnt_o (busy_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && req_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign granted_o       = res_q.granted;
  assign is_busy_o       = res_q.is_busy;
  assign busy_count_o    = res_q.busy_count;
  assign grant_total_o   = res_q.grant_total;
  assign release_total_o = res_q.release_total;

  // running busy count tracks the bitmap
  a_cnt_matches_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_map) == int'(busy_cnt))
    else $error("busy count out of step with busy map");

  // a grant names a real channel and leaves at least one busy
  a_grant_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (granted_o != '0) |->
      (int'(granted_o) <= CHANNELS) && (busy_count_o != '0) && !is_busy_o)
    else $error("grant out of range or inconsistent");

  // a pending request reaches the result register when it drains
  a_req_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_q && advance |=> res_vld_q)
    else $error("request lost between stages");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(busy_count_o) <= CHANNELS)
    else $error("busy count above channel count");

endmodule
